/* design/dfd_pkg.sv */
// Shared types and constants for the Doppler fractional delay line.
`default_nettype none
package dfd_pkg;

    localparam int SampleW     = 16;
    localparam int DelayW      = 28;
    localparam int FracW       = 16;
    localparam int RampW       = 16;
    localparam int StepW       = 29;
    localparam int DefaultDepth = 4096;

    localparam logic ReqTick = 1'b0;
    localparam logic ReqSet  = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic signed [SampleW-1:0] sample_in;
        logic [DelayW-1:0]         target_delay;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_OUT,
        S_DIV
    } t_state;

    typedef struct packed {
        logic start;
        logic neg;
    } t_div_ctl;

endpackage
`default_nettype wire

/* design/dfd_ifs.sv */
// Channel interfaces: input items, result items and the ramp length write port.
`default_nettype none
interface dfd_item_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      req_type;
    logic signed [dfd_pkg::SampleW-1:0]        sample_in;
    logic [dfd_pkg::DelayW-1:0]                target_delay;
    modport source (output valid, req_type, sample_in, target_delay, input ready);
    modport sink   (input valid, req_type, sample_in, target_delay, output ready);
endinterface

interface dfd_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [dfd_pkg::SampleW-1:0] sample_out;
    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

interface dfd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dfd_pkg::RampW-1:0]    ramp_length;
    modport source (output valid, ramp_length, input ready);
    modport sink   (input valid, ramp_length, output ready);
endinterface
`default_nettype wire

/* design/dfd_front.sv */
// Front end: accepts items into a two-entry queue toward the back end.
`default_nettype none
module dfd_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    dfd_item_if.sink         i_in,
    output logic             o_q_valid,
    output dfd_pkg::t_item   o_q_item,
    input  wire              i_q_pop
);
    dfd_pkg::t_item r_ent [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic           push;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_ent[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr] <= '{req_type: i_in.req_type, sample_in: i_in.sample_in,
                             target_delay: i_in.target_delay};
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (i_q_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule
`default_nettype wire

/* design/dfd_div.sv */
// Restoring divider, one quotient bit per cycle: |delay distance| / ramp length.
`default_nettype none
module dfd_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire [dfd_pkg::DelayW-1:0]        i_dividend,
    input  wire [dfd_pkg::RampW-1:0]         i_divisor,
    output logic                             o_done,
    output logic [dfd_pkg::DelayW-1:0]       o_quot
);
    localparam int CntW = $clog2(dfd_pkg::DelayW + 1);

    logic [dfd_pkg::RampW:0]    r_rem;
    logic [dfd_pkg::DelayW-1:0] r_q;
    logic [dfd_pkg::RampW-1:0]  r_div;
    logic [CntW-1:0]            r_n;
    logic                       r_busy;
    logic                       r_done;
    logic [dfd_pkg::RampW:0]    trial;
    logic                       fits;

    assign trial  = {r_rem[dfd_pkg::RampW-1:0], r_q[dfd_pkg::DelayW-1]};
    assign fits   = trial >= {1'b0, r_div};
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_n   <= CntW'(dfd_pkg::DelayW);
        end else if (r_busy) begin
            r_rem <= fits ? trial - {1'b0, r_div} : trial;
            r_q   <= {r_q[dfd_pkg::DelayW-2:0], fits};
            r_n   <= r_n - 1'b1;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_n == CntW'(1));
            if (i_start) r_busy <= 1'b1;
            else if (r_busy && r_n == CntW'(1)) r_busy <= 1'b0;
        end
    end
endmodule
`default_nettype wire

/* design/dfd_back.sv */
// Back end: buffer memory, interpolation, delay glide and set-delay handling.
`default_nettype none
module dfd_back #(
    parameter int DEPTH = dfd_pkg::DefaultDepth
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_q_valid,
    input  wire dfd_pkg::t_item         i_q_item,
    output logic                        o_q_pop,
    input  wire [dfd_pkg::RampW-1:0]    i_ramp_length,
    dfd_result_if.source                o_out
);
    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam longint MaxFull = longint'(DEPTH - 1) <<< dfd_pkg::FracW;
    localparam logic [dfd_pkg::DelayW-1:0] MaxDelay =
        (MaxFull > longint'(28'hFFFFFFF)) ? 28'hFFFFFFF : dfd_pkg::DelayW'(MaxFull);
    localparam logic [16:0] KMax  = 17'(DEPTH - 1);
    localparam logic [AW:0] DepthW = (AW+1)'(DEPTH);
    localparam logic [AW:0] DepthM1 = (AW+1)'(DEPTH - 1);

    dfd_pkg::t_state r_state, n_state;

    logic [15:0]               r_mem [DEPTH];
    logic [15:0]               r_rd_a, r_rd_b;
    logic                      r_ok_a, r_ok_b;
    logic [AW-1:0]             r_wp;
    logic [FW-1:0]             r_fill;
    logic [dfd_pkg::DelayW-1:0] r_cur, r_goal;
    logic signed [dfd_pkg::StepW-1:0] r_step;
    logic [dfd_pkg::RampW-1:0] r_cnt;
    logic [15:0]               r_sample;
    logic signed [16:0]        r_a;
    logic signed [33:0]        r_prod;
    logic                      r_out_valid;
    logic signed [15:0]        r_out_data;
    logic                      r_neg;

    // control
    logic            slot_free;
    logic            take_tick, take_set;
    dfd_pkg::t_div_ctl div_ctl;
    logic            div_done;
    logic [dfd_pkg::DelayW-1:0] div_quot;

    // tap addressing
    logic [16:0]     k_a, k_b;
    logic [AW-1:0]   a_addr, b_addr;
    logic [AW:0]     t_a, t_b;

    // set-delay math
    logic [dfd_pkg::DelayW-1:0] cur_snap, goal_new;
    logic signed [dfd_pkg::DelayW:0] delta;
    logic [dfd_pkg::DelayW-1:0] dist_abs;

    // sample math
    logic signed [16:0] av, bv;
    logic signed [16:0] fr;
    logic signed [34:0] acc;
    logic signed [18:0] rnd;
    logic signed [15:0] sat;
    logic signed [dfd_pkg::DelayW+1:0] nd;
    logic [dfd_pkg::DelayW-1:0] nd_clamped;

    assign slot_free      = !r_out_valid || o_out.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.sample_out = r_out_data;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dfd_pkg::S_IDLE: begin
                if (i_q_valid && i_q_item.req_type == dfd_pkg::ReqTick) n_state = dfd_pkg::S_RD;
                else if (i_q_valid && i_ramp_length != '0) n_state = dfd_pkg::S_DIV;
            end
            dfd_pkg::S_RD:  n_state = dfd_pkg::S_MUL;
            dfd_pkg::S_MUL: n_state = dfd_pkg::S_OUT;
            dfd_pkg::S_OUT: if (slot_free) n_state = dfd_pkg::S_IDLE;
            dfd_pkg::S_DIV: if (div_done) n_state = dfd_pkg::S_IDLE;
            default:        n_state = dfd_pkg::S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        take_tick = 1'b0;
        take_set  = 1'b0;
        case (r_state)
            dfd_pkg::S_IDLE: begin
                take_tick = i_q_valid && i_q_item.req_type == dfd_pkg::ReqTick;
                take_set  = i_q_valid && i_q_item.req_type == dfd_pkg::ReqSet;
            end
            default: ;
        endcase
        o_q_pop       = take_tick || take_set;
        div_ctl.start = take_set && (i_ramp_length != '0);
        div_ctl.neg   = delta < 0;
    end

    // taps i and i+1 behind the write pointer, capped to the buffer
    always_comb begin
        k_a = {5'd0, r_cur[dfd_pkg::DelayW-1:dfd_pkg::FracW]};
        k_b = k_a + 17'd1;
        if (k_a > KMax) k_a = KMax;
        if (k_b > KMax) k_b = KMax;
        t_a = {1'b0, r_wp} + DepthM1 - {1'b0, k_a[AW-1:0]};
        t_b = {1'b0, r_wp} + DepthM1 - {1'b0, k_b[AW-1:0]};
        if (t_a >= DepthW) t_a = t_a - DepthW;
        if (t_b >= DepthW) t_b = t_b - DepthW;
        a_addr = t_a[AW-1:0];
        b_addr = t_b[AW-1:0];
    end

    always_comb begin
        cur_snap = (r_cnt != '0) ? r_goal : r_cur;
        goal_new = (i_q_item.target_delay > MaxDelay) ? MaxDelay : i_q_item.target_delay;
        delta    = $signed({1'b0, goal_new}) - $signed({1'b0, cur_snap});
        dist_abs = (delta < 0) ? dfd_pkg::DelayW'(-delta) : dfd_pkg::DelayW'(delta);
    end

    always_comb begin
        av  = r_ok_a ? 17'(signed'(r_rd_a)) : 17'sd0;
        bv  = r_ok_b ? 17'(signed'(r_rd_b)) : 17'sd0;
        fr  = $signed({1'b0, r_cur[dfd_pkg::FracW-1:0]});
        acc = ($signed(35'(r_a)) <<< 16) + 35'(r_prod) + 35'sd32768;
        rnd = 19'(acc >>> 16);
        if (rnd > 19'sd32767) sat = 16'sd32767;
        else if (rnd < -19'sd32768) sat = -16'sd32768;
        else sat = 16'(rnd);
        nd = $signed({2'b0, r_cur}) + (dfd_pkg::DelayW+2)'(r_step);
        if (nd < 0) nd_clamped = '0;
        else if (nd > $signed({2'b0, MaxDelay})) nd_clamped = MaxDelay;
        else nd_clamped = dfd_pkg::DelayW'(nd);
    end

    dfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_ctl.start),
        .i_dividend (dist_abs),
        .i_divisor  (i_ramp_length),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // buffer memory: two registered read ports, one write port
    always_ff @(posedge i_clk) begin
        if (r_state == dfd_pkg::S_RD) begin
            r_rd_a <= r_mem[a_addr];
            r_rd_b <= r_mem[b_addr];
        end
        if (r_state == dfd_pkg::S_OUT && slot_free) r_mem[r_wp] <= r_sample;
    end

    always_ff @(posedge i_clk) begin
        if (take_tick) r_sample <= i_q_item.sample_in;
        if (r_state == dfd_pkg::S_MUL) begin
            r_a    <= av;
            r_prod <= (bv - av) * fr;
        end
        if (r_state == dfd_pkg::S_OUT && slot_free) r_out_data <= sat;
        if (div_ctl.start) r_neg <= div_ctl.neg;
        if (!i_rst_n) begin
            r_state     <= dfd_pkg::S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_cur       <= '0;
            r_goal      <= '0;
            r_step      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_ok_a      <= 1'b0;
            r_ok_b      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == dfd_pkg::S_RD) begin
                // slots never written read as zero
                r_ok_a <= 18'(k_a) < 18'(r_fill);
                r_ok_b <= 18'(k_b) < 18'(r_fill);
            end
            if (o_out.ready) r_out_valid <= 1'b0;
            if (r_state == dfd_pkg::S_OUT && slot_free) begin
                r_out_valid <= 1'b1;
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill != FW'(DEPTH)) r_fill <= r_fill + 1'b1;
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                    r_cur <= (r_cnt == dfd_pkg::RampW'(1)) ? r_goal : nd_clamped;
                end
            end
            if (take_set) begin
                r_cur  <= cur_snap;
                r_goal <= goal_new;
                r_cnt  <= (i_ramp_length == '0) ? dfd_pkg::RampW'(1) : i_ramp_length;
                r_step <= '0;
            end
            if (r_state == dfd_pkg::S_DIV && div_done) begin
                r_step <= r_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
            end
        end
    end
endmodule
`default_nettype wire

/* design/doppler_fractional_delay_line.sv */
// Top level of the Doppler fractional delay line.
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    req_type, sample_in, target_delay
//  o_out    out  valid/ready    sample_out
//  i_cfg    in   valid/ready    ramp_length (always ready)
//
// A sample item passes the back end in order: memory read, multiply,
// round/saturate and buffer write. A set-delay item with a nonzero ramp
// length waits for the bit-serial divider; with a zero ramp it needs none.
// A two-entry queue accepts until full while the back end works or o_out stalls.
// Reset is synchronous; never-written buffer slots read as zero via a fill count.
`default_nettype none
module doppler_fractional_delay_line #(
    parameter int DEPTH = dfd_pkg::DefaultDepth
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    dfd_item_if.sink     i_in,
    dfd_result_if.source o_out,
    dfd_cfg_if.sink      i_cfg
);
    logic [dfd_pkg::RampW-1:0] r_ramp_length;
    logic                      q_valid;
    logic                      q_pop;
    dfd_pkg::t_item            q_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ramp_length <= '0;
        else if (i_cfg.valid) r_ramp_length <= i_cfg.ramp_length;
    end

    dfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    dfd_back #(.DEPTH(DEPTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .i_ramp_length (r_ramp_length),
        .o_out         (o_out)
    );

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out.valid) else $error("result right after reset");

    a_set_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q_item.req_type == dfd_pkg::ReqSet && !o_out.valid) |=> !o_out.valid)
        else $error("set-delay item produced a result");
endmodule
`default_nettype wire
